>>> rtl/rnmb_pkg.sv
// Shared types, field widths and codes for the radius neighbor mask builder.
package rnmb_pkg;

  localparam int SLOT_W         = 6;
  localparam int ROLE_W         = 2;
  localparam int MODE_W         = 2;
  localparam int IN_COORD_W     = 16;
  localparam int SQ_W           = 38;
  localparam int MASK_W         = 64;
  localparam int COUNT_W        = 6;
  localparam int CFG_IDX_W      = 1;
  localparam int IN_DATA_W      = 56;
  localparam int OUT_DATA_W     = 80;
  localparam int OUT_PAD_W      = OUT_DATA_W - (SLOT_W + MASK_W + COUNT_W);
  localparam int MAX_AGENTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_SQ = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [ROLE_W-1:0] {
    ROLE_BODY    = 2'd0,
    ROLE_START   = 2'd1,
    ROLE_GOAL    = 2'd2,
    ROLE_REMOVED = 2'd3
  } role_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QREAD,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Control that travels alongside one candidate through the distance pipe.
  typedef struct packed {
    logic              vld;
    logic              last;
    logic              cand_vld;
    logic [SLOT_W-1:0] idx;
  } sweep_ctl_t;

endpackage

>>> rtl/radius_neighbor_mask_builder_core.sv
// Top level of the radius neighbor mask builder: agent store, query sequencer and result register.
// Loads and clears take effect at their transfer edge. A query on a valid slot reads its entry, sweeps
// every slot through the distance pipe and registers its result; one on an empty or out-of-range
// slot goes to the result register without a sweep. Requests of any mode are accepted only while
// idle, so a query holds off later requests; the sweep uses the single read port one entry per cycle.
// Reset (rst, synchronous): clears all valid marks, both radius registers and the result valid.
module radius_neighbor_mask_builder_core
  import rnmb_pkg::*;
#(
  parameter int MAX_AGENTS = MAX_AGENTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // Fields from bit 0: slot[5:0], role[7:6], x_coord[23:8], y_coord[39:24], z_coord[55:40].
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // Fields from bit 0: mode[1:0].
  input  logic [MODE_W-1:0]     s_tuser,
  // Result stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // Fields from bit 0: query_slot[5:0], neighbor_mask[69:6], neighbor_count[75:70], zeros.
  output logic [OUT_DATA_W-1:0] m_tdata,
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [SQ_W-1:0]       cfg_wdata
);

  localparam int AW = $clog2(MAX_AGENTS);
  localparam int EW = ROLE_W + 3 * COORD_BITS;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_AGENTS - 1);

  // Input field decode.
  logic [SLOT_W-1:0]            in_slot;
  logic [ROLE_W-1:0]            in_role;
  logic signed [IN_COORD_W-1:0] in_x, in_y, in_z;
  logic signed [COORD_BITS-1:0] st_x, st_y, st_z;
  logic [MODE_W-1:0]            in_mode;
  logic [AW-1:0]                in_idx;
  logic                         slot_ok;
  logic                         accept;
  logic                         is_load, is_query, is_clear;

  // Configuration registers.
  logic [SQ_W-1:0] radius_sq;
  logic [SQ_W-1:0] epsilon_sq;

  // Store and sequencer.
  logic [MAX_AGENTS-1:0] slot_valid;
  logic                  ram_we;
  logic [EW-1:0]         ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [EW-1:0]         ram_rdata;
  state_t                state, state_next;
  logic [AW-1:0]         cnt;
  logic                  issue;
  logic                  issue_last;
  sweep_ctl_t            issue_ctl;
  sweep_ctl_t            ctl_d;
  logic [EW-1:0]         q_entry;
  logic [SLOT_W-1:0]     q_slot;
  sweep_ctl_t            hit_ctl;
  logic                  hit;
  logic [MASK_W-1:0]     mask_acc;
  logic [COUNT_W-1:0]    hit_count;
  logic                  out_free;
  logic [OUT_DATA_W-1:0] out_data;

  assign in_slot = s_tdata[SLOT_W-1:0];
  assign in_role = s_tdata[SLOT_W +: ROLE_W];
  assign in_x    = s_tdata[SLOT_W + ROLE_W +: IN_COORD_W];
  assign in_y    = s_tdata[SLOT_W + ROLE_W + IN_COORD_W +: IN_COORD_W];
  assign in_z    = s_tdata[SLOT_W + ROLE_W + 2*IN_COORD_W +: IN_COORD_W];
  assign in_mode = s_tuser;
  assign in_idx  = in_slot[AW-1:0];

  // Coordinates are sign-extended or wrapped to the stored width.
  assign st_x = COORD_BITS'(in_x);
  assign st_y = COORD_BITS'(in_y);
  assign st_z = COORD_BITS'(in_z);

  assign slot_ok = (SLOT_W+1)'(in_slot) < (SLOT_W+1)'(MAX_AGENTS);
  assign accept  = s_tvalid && s_tready;

  always_comb begin
    is_load  = 1'b0;
    is_query = 1'b0;
    is_clear = 1'b0;
    unique case (in_mode)
      MODE_LOAD:  is_load  = 1'b1;
      MODE_QUERY: is_query = 1'b1;
      MODE_CLEAR: is_clear = 1'b1;
      default:    ;
    endcase
  end

  // Configuration registers take any write, also while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_sq  <= '0;
      epsilon_sq <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_RADIUS_SQ:  radius_sq  <= cfg_wdata;
        CFG_EPSILON_SQ: epsilon_sq <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // Valid marks live in flops so a clear wipes every slot at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (accept && is_clear) begin
      slot_valid <= '0;
    end else if (accept && is_load && slot_ok) begin
      slot_valid[in_idx] <= 1'b1;
    end
  end

  // Agent store entry: role in the low bits, then x, y and z.
  assign ram_we    = accept && is_load && slot_ok;
  assign ram_wdata = {st_z, st_y, st_x, in_role};

  rnmb_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_AGENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next-state logic. The query entry is read at accept, then the sweep
  // issues one candidate address per cycle starting in the read cycle.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_query) begin
          if (slot_ok && slot_valid[in_idx]) begin
            state_next = ST_QREAD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_QREAD: begin
        state_next = issue_last ? ST_DRAIN : ST_SWEEP;
      end
      ST_SWEEP: begin
        if (issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (hit_ctl.vld && hit_ctl.last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    s_tready  = 1'b0;
    issue     = 1'b0;
    ram_raddr = cnt;
    unique case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        ram_raddr = in_idx;
      end
      ST_QREAD, ST_SWEEP: begin
        issue = 1'b1;
      end
      ST_DRAIN, ST_DONE: ;
      default: ;
    endcase
  end

  assign issue_last         = issue && (cnt == LAST_IDX);
  assign issue_ctl.vld      = issue;
  assign issue_ctl.last     = issue_last;
  assign issue_ctl.cand_vld = slot_valid[cnt];
  assign issue_ctl.idx      = SLOT_W'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ctl_d <= '0;
    end else begin
      state <= state_next;
      ctl_d <= issue_ctl;
    end
  end

  // Sweep counter, query latch and result accumulation.
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt       <= '0;
      q_slot    <= in_slot;
      mask_acc  <= '0;
      hit_count <= '0;
    end else begin
      if (issue) begin
        cnt <= AW'(cnt + 1'b1);
      end
      if (hit_ctl.vld && hit) begin
        mask_acc[hit_ctl.idx] <= 1'b1;
        hit_count             <= COUNT_W'(hit_count + 1'b1);
      end
    end
    if (state == ST_QREAD) begin
      q_entry <= ram_rdata;
    end
  end

  // Candidate data comes from the registered read port, aligned with ctl_d.
  rnmb_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk        (clk),
    .rst        (rst),
    .radius_sq  (radius_sq),
    .epsilon_sq (epsilon_sq),
    .q_entry    (q_entry),
    .q_slot     (q_slot),
    .cand_entry (ram_rdata),
    .ctl_in     (ctl_d),
    .hit_ctl    (hit_ctl),
    .hit        (hit)
  );

  // Result register: holds a finished result while loads and clears go on.
  assign out_free = !m_tvalid || m_tready;
  assign out_data = {{OUT_PAD_W{1'b0}}, hit_count, mask_acc, q_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= out_data;
    end
  end

endmodule

>>> rtl/rnmb_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module rnmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/rnmb_dist.sv
// Four-stage squared-distance and neighbor test pipeline for one candidate per cycle.
module rnmb_dist
  import rnmb_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [SQ_W-1:0]                 radius_sq,
  input  logic [SQ_W-1:0]                 epsilon_sq,
  input  logic [ROLE_W+3*COORD_BITS-1:0]  q_entry,
  input  logic [SLOT_W-1:0]               q_slot,
  input  logic [ROLE_W+3*COORD_BITS-1:0]  cand_entry,
  input  sweep_ctl_t                      ctl_in,
  output sweep_ctl_t                      hit_ctl,
  output logic                            hit
);

  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 2;
  localparam int CW  = (SW > SQ_W) ? SW : SQ_W;

  logic signed [COORD_BITS-1:0] qc [3];
  logic signed [COORD_BITS-1:0] cc [3];
  logic signed [DW-1:0]         diff [3];
  logic signed [PW-1:0]         prod [3];
  logic [ROLE_W-1:0]            q_role;
  logic [ROLE_W-1:0]            c_role;
  logic                         pre;

  sweep_ctl_t           s1_ctl, s2_ctl, s3_ctl;
  logic                 s1_pre, s2_pre, s3_pre;
  logic signed [DW-1:0] s1_d [3];
  logic [PW-1:0]        s2_sq [3];
  logic [SW-1:0]        s3_sum;
  logic                 le_r, gt_eps;

  assign q_role = q_entry[ROLE_W-1:0];
  assign c_role = cand_entry[ROLE_W-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc[k]   = q_entry[ROLE_W + k*COORD_BITS +: COORD_BITS];
      cc[k]   = cand_entry[ROLE_W + k*COORD_BITS +: COORD_BITS];
      diff[k] = DW'(qc[k]) - DW'(cc[k]);
      prod[k] = s1_d[k] * s1_d[k];
    end
  end

  // A body only sees other bodies; start and goal see every role.
  always_comb begin
    if (q_role == ROLE_BODY) begin
      pre = ctl_in.cand_vld && (ctl_in.idx != q_slot) && (c_role == ROLE_BODY);
    end else if (q_role == ROLE_START || q_role == ROLE_GOAL) begin
      pre = ctl_in.cand_vld;
    end else begin
      pre = 1'b0;
    end
  end

  assign le_r   = CW'(s3_sum) <= CW'(radius_sq);
  assign gt_eps = CW'(s3_sum) >  CW'(epsilon_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl  <= '0;
      s2_ctl  <= '0;
      s3_ctl  <= '0;
      hit_ctl <= '0;
    end else begin
      s1_ctl  <= ctl_in;
      s2_ctl  <= s1_ctl;
      s3_ctl  <= s2_ctl;
      hit_ctl <= s3_ctl;
    end
  end

  always_ff @(posedge clk) begin
    s1_pre <= pre;
    for (int k = 0; k < 3; k++) begin
      s1_d[k]  <= diff[k];
      s2_sq[k] <= prod[k];
    end
    s2_pre <= s1_pre;
    s3_sum <= SW'(s2_sq[0]) + SW'(s2_sq[1]) + SW'(s2_sq[2]);
    s3_pre <= s2_pre;
    hit    <= s3_pre && le_r && ((q_role == ROLE_BODY) || gt_eps);
  end

endmodule

>>> rtl/rnmb_checker.sv
// Port-level checker for the radius neighbor mask builder and its bind statement.
module rnmb_checker
  import rnmb_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The count field always matches the number of mask bits set.
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[75:70] == COUNT_W'($countones(m_tdata[69:6])))
    else $error("neighbor count does not match mask");

  // An agent is never reported as its own neighbor.
  a_no_self: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[69:6] >> m_tdata[5:0]) & 64'd1) == 64'd0)
    else $error("queried slot set in its own mask");

  // Reset drops any pending result.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind radius_neighbor_mask_builder_core rnmb_checker u_rnmb_checker (.*);
